/* hdl/bci_pkg.sv */
// shared constants and types of the bilinear cell interpolator
`default_nettype none

package bci_pkg;

   localparam int MARGIN_W = 16;

   // register indexes of the configuration port
   localparam logic CSR_BOUND_MARGIN = 1'b0;

   typedef struct packed {
      logic oob;
      logic degen;
   } bci_flags_type;

   typedef struct packed {
      logic          neg;
      bci_flags_type flags;
   } bci_ctrl_type;

endpackage

`default_nettype wire

/* hdl/bci_div_step.sv */
// one restoring division step: one quotient bit per pipeline stage
`default_nettype none

module bci_div_step
   import bci_pkg::*;
#(
   parameter int NW = 102,
   parameter int DW = 68,
   parameter int SW = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire logic                 in_valid,
   input  wire logic [DW-1:0]        in_rem,
   input  wire logic [NW-1:0]        in_numq,
   input  wire logic [DW-1:0]        in_den,
   input  wire bci_ctrl_type         in_ctrl,
   input  wire logic [SW-1:0]        in_side,
   output logic                      out_valid,
   output logic [DW-1:0]             out_rem,
   output logic [NW-1:0]             out_numq,
   output logic [DW-1:0]             out_den,
   output bci_ctrl_type              out_ctrl,
   output logic [SW-1:0]             out_side
);

   logic [DW:0]   trial;
   logic [DW:0]   diff;
   logic          take;
   logic [DW-1:0] rem_in;
   logic [NW-1:0] numq_in;
   logic          valid_ff;
   logic [DW-1:0] rem_ff;
   logic [NW-1:0] numq_ff;
   logic [DW-1:0] den_ff;
   bci_ctrl_type  ctrl_ff;
   logic [SW-1:0] side_ff;

   assign trial   = {in_rem, in_numq[NW-1]};
   assign diff    = trial - {1'b0, in_den};
   assign take    = ~diff[DW];
   // remainder stays below the divisor, so the kept trial fits
   assign rem_in  = take ? diff[DW-1:0] : trial[DW-1:0];
   assign numq_in = {in_numq[NW-2:0], take};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff  <= rem_in;
         numq_ff <= numq_in;
         den_ff  <= in_den;
         ctrl_ff <= in_ctrl;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_numq  = numq_ff;
   assign out_den   = den_ff;
   assign out_ctrl  = ctrl_ff;
   assign out_side  = side_ff;

endmodule

`default_nettype wire

/* hdl/bilinear_cell_interpolator_unit.sv */
// top level of the bilinear cell interpolator
//
// Takes one request per cycle and returns one result per request, in order.
// The pipe has eight stages of bound widening, products, wide sums and
// magnitudes, then a divider that resolves one quotient bit per stage over
// 3*DATA_WIDTH+6 stages, then the output register.
// The whole pipe moves together and holds while the result waits on rsp_stall.
// A target outside the widened cell is still interpolated and flagged; a cell
// of zero width or height returns value_bottom_left and raises degenerate_cell.
`default_nettype none

module bilinear_cell_interpolator_unit
   import bci_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [DATA_WIDTH-1:0] req_x_low,
   input  wire logic signed [DATA_WIDTH-1:0] req_y_low,
   input  wire logic signed [DATA_WIDTH-1:0] req_x_high,
   input  wire logic signed [DATA_WIDTH-1:0] req_y_high,
   input  wire logic signed [DATA_WIDTH-1:0] req_value_bottom_left,
   input  wire logic signed [DATA_WIDTH-1:0] req_value_bottom_right,
   input  wire logic signed [DATA_WIDTH-1:0] req_value_top_left,
   input  wire logic signed [DATA_WIDTH-1:0] req_value_top_right,
   input  wire logic signed [DATA_WIDTH-1:0] req_target_x,
   input  wire logic signed [DATA_WIDTH-1:0] req_target_y,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0]      rsp_interpolated,
   output logic                              rsp_out_of_bounds,
   output logic                              rsp_degenerate_cell,
   output logic                              rsp_saturated,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [2:0]                   csr_paddr,
   input  wire logic [31:0]                  csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   localparam int W  = DATA_WIDTH;
   localparam int CW = W + 1;        // widened bounds
   localparam int EW = W + 2;        // spans and distances
   localparam int PW = EW + W;       // distance times corner value
   localparam int SW = PW + 1;       // sum of two such products
   localparam int L  = W + 1;        // split point of the second multiply
   localparam int MW = 2 * EW;       // partial products
   localparam int NW = SW + EW + 1;  // numerator
   localparam int DW = 2 * EW;       // denominator

   // configuration
   logic [MARGIN_W-1:0] margin_ff;
   logic                csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= '0;
      end else if (csr_write && csr_paddr[2] == CSR_BOUND_MARGIN) begin
         margin_ff <= csr_pwdata[MARGIN_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_BOUND_MARGIN)
                       ? {{(32-MARGIN_W){1'b0}}, margin_ff} : 32'd0;

   // pipe control
   logic advance;
   assign advance   = ~rsp_valid | ~rsp_stall;
   assign req_stall = ~advance;

   // stage 1: widened bounds
   logic signed [CW-1:0] m_c;
   logic signed [CW-1:0] x1_in, x2_in, y1_in, y2_in;
   logic                 v1_ff;
   logic signed [CW-1:0] x1_ff, x2_ff, y1_ff, y2_ff;
   logic signed [W-1:0]  tx1_ff, ty1_ff;
   logic signed [W-1:0]  q11_1_ff, q21_1_ff, q12_1_ff, q22_1_ff;

   assign m_c   = $signed({{(CW-MARGIN_W){1'b0}}, margin_ff});
   assign x1_in = CW'(req_x_low) - m_c;
   assign y1_in = CW'(req_y_low) - m_c;
   assign x2_in = CW'(req_x_high) + m_c;
   assign y2_in = CW'(req_y_high) + m_c;

   // stage 2: distances, spans, bounds check
   logic signed [CW-1:0] tx_c, ty_c;
   logic signed [EW-1:0] wa_in, wb_in, wc_in, wd_in, dx_in, dy_in;
   logic                 oob_in;
   logic                 v2_ff;
   logic signed [EW-1:0] wa_ff, wb_ff, wc2_ff, wd2_ff, dx_ff, dy_ff;
   logic                 oob2_ff;
   logic signed [W-1:0]  q11_2_ff, q21_2_ff, q12_2_ff, q22_2_ff;

   assign tx_c   = CW'(tx1_ff);
   assign ty_c   = CW'(ty1_ff);
   assign wa_in  = EW'(x2_ff) - EW'(tx_c);
   assign wb_in  = EW'(tx_c) - EW'(x1_ff);
   assign wc_in  = EW'(y2_ff) - EW'(ty_c);
   assign wd_in  = EW'(ty_c) - EW'(y1_ff);
   assign dx_in  = EW'(x2_ff) - EW'(x1_ff);
   assign dy_in  = EW'(y2_ff) - EW'(y1_ff);
   assign oob_in = (tx_c < x1_ff) | (tx_c > x2_ff) | (ty_c < y1_ff) | (ty_c > y2_ff);

   // stage 3: first products and the denominator
   logic signed [PW-1:0] p11_in, p21_in, p12_in, p22_in;
   logic signed [DW-1:0] den_in;
   bci_flags_type        flags3_in;
   logic                 v3_ff;
   logic signed [PW-1:0] p11_ff, p21_ff, p12_ff, p22_ff;
   logic signed [DW-1:0] den3_ff;
   logic signed [EW-1:0] wc3_ff, wd3_ff;
   bci_flags_type        flags3_ff;
   logic signed [W-1:0]  q11_3_ff;

   assign p11_in = PW'(wa_ff) * PW'(q11_2_ff);
   assign p21_in = PW'(wb_ff) * PW'(q21_2_ff);
   assign p12_in = PW'(wa_ff) * PW'(q12_2_ff);
   assign p22_in = PW'(wb_ff) * PW'(q22_2_ff);
   assign den_in = DW'(dx_ff) * DW'(dy_ff);
   assign flags3_in.oob   = oob2_ff;
   assign flags3_in.degen = (dx_ff == '0) | (dy_ff == '0);

   // stage 4: row sums
   logic signed [SW-1:0] s1_in, s2_in;
   logic                 v4_ff;
   logic signed [SW-1:0] s1_ff, s2_ff;
   logic signed [DW-1:0] den4_ff;
   logic signed [EW-1:0] wc4_ff, wd4_ff;
   bci_flags_type        flags4_ff;
   logic signed [W-1:0]  q11_4_ff;

   assign s1_in = SW'(p11_ff) + SW'(p21_ff);
   assign s2_in = SW'(p12_ff) + SW'(p22_ff);

   // stage 5: split products of the row sums by the y distances
   logic signed [MW-1:0] m1h_in, m1l_in, m2h_in, m2l_in;
   logic                 v5_ff;
   logic signed [MW-1:0] m1h_ff, m1l_ff, m2h_ff, m2l_ff;
   logic signed [DW-1:0] den5_ff;
   bci_flags_type        flags5_ff;
   logic signed [W-1:0]  q11_5_ff;

   assign m1h_in = MW'($signed(s1_ff[SW-1:L])) * MW'(wc4_ff);
   assign m1l_in = MW'($signed({1'b0, s1_ff[L-1:0]})) * MW'(wc4_ff);
   assign m2h_in = MW'($signed(s2_ff[SW-1:L])) * MW'(wd4_ff);
   assign m2l_in = MW'($signed({1'b0, s2_ff[L-1:0]})) * MW'(wd4_ff);

   // stage 6: add high and low halves separately
   logic signed [MW:0]   th_in, tl_in;
   logic                 v6_ff;
   logic signed [MW:0]   th_ff, tl_ff;
   logic signed [DW-1:0] den6_ff;
   bci_flags_type        flags6_ff;
   logic signed [W-1:0]  q11_6_ff;

   assign th_in = (MW+1)'(m1h_ff) + (MW+1)'(m2h_ff);
   assign tl_in = (MW+1)'(m1l_ff) + (MW+1)'(m2l_ff);

   // stage 7: full numerator
   logic signed [NW-1:0] num_in;
   logic                 v7_ff;
   logic signed [NW-1:0] num_ff;
   logic signed [DW-1:0] den7_ff;
   bci_flags_type        flags7_ff;
   logic signed [W-1:0]  q11_7_ff;

   assign num_in = (NW'(th_ff) <<< L) + NW'(tl_ff);

   // stage 8: magnitudes and quotient sign
   logic [NW-1:0] nmag_in;
   logic [DW-1:0] dmag_in;
   bci_ctrl_type  ctrl8_in;
   logic          v8_ff;
   logic [NW-1:0] nmag_ff;
   logic [DW-1:0] dmag_ff;
   bci_ctrl_type  ctrl8_ff;
   logic [W-1:0]  q11_8_ff;

   assign nmag_in        = num_ff[NW-1] ? NW'(-num_ff) : NW'(num_ff);
   assign dmag_in        = den7_ff[DW-1] ? DW'(-den7_ff) : DW'(den7_ff);
   assign ctrl8_in.neg   = num_ff[NW-1] ^ den7_ff[DW-1];
   assign ctrl8_in.flags = flags7_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x1_ff     <= x1_in;
         x2_ff     <= x2_in;
         y1_ff     <= y1_in;
         y2_ff     <= y2_in;
         tx1_ff    <= req_target_x;
         ty1_ff    <= req_target_y;
         q11_1_ff  <= req_value_bottom_left;
         q21_1_ff  <= req_value_bottom_right;
         q12_1_ff  <= req_value_top_left;
         q22_1_ff  <= req_value_top_right;

         wa_ff     <= wa_in;
         wb_ff     <= wb_in;
         wc2_ff    <= wc_in;
         wd2_ff    <= wd_in;
         dx_ff     <= dx_in;
         dy_ff     <= dy_in;
         oob2_ff   <= oob_in;
         q11_2_ff  <= q11_1_ff;
         q21_2_ff  <= q21_1_ff;
         q12_2_ff  <= q12_1_ff;
         q22_2_ff  <= q22_1_ff;

         p11_ff    <= p11_in;
         p21_ff    <= p21_in;
         p12_ff    <= p12_in;
         p22_ff    <= p22_in;
         den3_ff   <= den_in;
         wc3_ff    <= wc2_ff;
         wd3_ff    <= wd2_ff;
         flags3_ff <= flags3_in;
         q11_3_ff  <= q11_2_ff;

         s1_ff     <= s1_in;
         s2_ff     <= s2_in;
         den4_ff   <= den3_ff;
         wc4_ff    <= wc3_ff;
         wd4_ff    <= wd3_ff;
         flags4_ff <= flags3_ff;
         q11_4_ff  <= q11_3_ff;

         m1h_ff    <= m1h_in;
         m1l_ff    <= m1l_in;
         m2h_ff    <= m2h_in;
         m2l_ff    <= m2l_in;
         den5_ff   <= den4_ff;
         flags5_ff <= flags4_ff;
         q11_5_ff  <= q11_4_ff;

         th_ff     <= th_in;
         tl_ff     <= tl_in;
         den6_ff   <= den5_ff;
         flags6_ff <= flags5_ff;
         q11_6_ff  <= q11_5_ff;

         num_ff    <= num_in;
         den7_ff   <= den6_ff;
         flags7_ff <= flags6_ff;
         q11_7_ff  <= q11_6_ff;

         nmag_ff   <= nmag_in;
         dmag_ff   <= dmag_in;
         ctrl8_ff  <= ctrl8_in;
         q11_8_ff  <= q11_7_ff;
      end
   end

   // divider: one quotient bit per stage, quotient shifts in below the numerator
   logic          dv   [0:NW];
   logic [DW-1:0] drem [0:NW];
   logic [NW-1:0] dnq  [0:NW];
   logic [DW-1:0] dden [0:NW];
   bci_ctrl_type  dctl [0:NW];
   logic [W-1:0]  dq11 [0:NW];

   assign dv[0]   = v8_ff;
   assign drem[0] = '0;
   assign dnq[0]  = nmag_ff;
   assign dden[0] = dmag_ff;
   assign dctl[0] = ctrl8_ff;
   assign dq11[0] = q11_8_ff;

   for (genvar i = 0; i < NW; i++) begin : g_div
      bci_div_step #(
         .NW(NW),
         .DW(DW),
         .SW(W)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (dv[i]),
         .in_rem    (drem[i]),
         .in_numq   (dnq[i]),
         .in_den    (dden[i]),
         .in_ctrl   (dctl[i]),
         .in_side   (dq11[i]),
         .out_valid (dv[i+1]),
         .out_rem   (drem[i+1]),
         .out_numq  (dnq[i+1]),
         .out_den   (dden[i+1]),
         .out_ctrl  (dctl[i+1]),
         .out_side  (dq11[i+1])
      );
   end

   // output stage: saturate, apply sign, or pass the corner value for a flat cell
   logic [NW-1:0] lim_c;
   logic          sat_c;
   logic [W-1:0]  mag_c;
   logic [W-1:0]  val_in;
   logic          sat_in;
   logic          out_valid_ff;
   logic [W-1:0]  out_val_ff;
   logic          out_oob_ff;
   logic          out_degen_ff;
   logic          out_sat_ff;

   assign lim_c  = (NW'(1) << (W - 1)) - {{(NW-1){1'b0}}, ~dctl[NW].neg};
   assign sat_c  = dnq[NW] > lim_c;
   assign mag_c  = sat_c ? lim_c[W-1:0] : dnq[NW][W-1:0];
   assign val_in = dctl[NW].flags.degen ? dq11[NW]
                   : (dctl[NW].neg ? W'(-mag_c) : mag_c);
   assign sat_in = sat_c & ~dctl[NW].flags.degen;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= dv[NW];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_val_ff   <= val_in;
         out_oob_ff   <= dctl[NW].flags.oob;
         out_degen_ff <= dctl[NW].flags.degen;
         out_sat_ff   <= sat_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_interpolated    = $signed(out_val_ff);
   assign rsp_out_of_bounds   = out_oob_ff;
   assign rsp_degenerate_cell = out_degen_ff;
   assign rsp_saturated       = out_sat_ff;

endmodule

`default_nettype wire

/* hdl/bci_checker.sv */
// port-level checks of the bilinear cell interpolator and their binding
`default_nettype none

module bci_checker
   import bci_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_stall,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_stall,
   input wire logic signed [DATA_WIDTH-1:0] rsp_interpolated,
   input wire logic                         rsp_degenerate_cell,
   input wire logic                         rsp_saturated
);

   localparam logic [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   // a flat cell returns the corner value and never clips
   a_degen_no_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate_cell |-> !rsp_saturated)
      else $error("degenerate result marked saturated");

   // a clipped result sits on a range bound
   a_sat_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         (rsp_interpolated == $signed(MAX_VAL)) || (rsp_interpolated == $signed(MIN_VAL)))
      else $error("saturated result not at a bound");

   // the pipe holds the request side while a result is stuck
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken while result blocked");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_interpolated))
      else $error("stalled result changed");

endmodule

bind bilinear_cell_interpolator_unit bci_checker #(.DATA_WIDTH(DATA_WIDTH)) u_bci_checker (.*);

`default_nettype wire
